/* sv/lgo_pkg.sv */
// ----------------------------------------------------------------------------
// lgo_pkg
// Shared types and constants for the luma gain/offset scanline block.
// ----------------------------------------------------------------------------
package lgo_pkg;

	localparam int PixW     = 8;
	localparam int GainW    = 9;
	localparam int OffsetW  = 10;
	localparam int StepW    = 8;
	localparam int PhaseW   = StepW + 1;
	localparam int CfgIdxW  = 2;
	localparam int CfgDataW = 10;

	// pixel * gain at full width, plus room for the rounding term
	localparam int ProdW    = PixW + GainW;
	localparam int Shift    = 7;
	localparam int ScaledW  = ProdW - Shift;
	localparam int SumW     = ScaledW + 2;

	localparam logic [ProdW-1:0]   Round      = ProdW'(64);
	localparam logic [GainW-1:0]   GainReset  = GainW'(128);
	localparam logic [OffsetW-1:0] OffsetReset = '0;
	localparam logic [StepW-1:0]   StepReset  = '0;
	localparam logic [PixW-1:0]    PixMax     = '1;

	typedef enum logic [CfgIdxW-1:0] {
		REG_GAIN   = 2'd0,
		REG_OFFSET = 2'd1,
		REG_STEP   = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [GainW-1:0]   gain;
		logic [OffsetW-1:0] offset;
	} adj_cfg_t;

endpackage

/* sv/lgo_if.sv */
// ----------------------------------------------------------------------------
// lgo_if
// Valid/ready channels of the luma gain/offset block: pixels in, pixels out,
// and the register write port.
// ----------------------------------------------------------------------------
interface lgo_pix_in_if;
	logic                    valid;
	logic                    ready;
	logic [lgo_pkg::PixW-1:0] pixel;
	logic                    line_end;
	logic                    frame_end;

	modport source (output valid, pixel, line_end, frame_end, input ready);
	modport sink   (input valid, pixel, line_end, frame_end, output ready);
endinterface

interface lgo_pix_out_if;
	logic                    valid;
	logic                    ready;
	logic [lgo_pkg::PixW-1:0] result_pixel;
	logic                    result_line_end;
	logic                    result_frame_end;

	modport source (output valid, result_pixel, result_line_end, result_frame_end,
		input ready);
	modport sink   (input valid, result_pixel, result_line_end, result_frame_end,
		output ready);
endinterface

interface lgo_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [lgo_pkg::CfgIdxW-1:0]  index;
	logic [lgo_pkg::CfgDataW-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

/* sv/lgo_adjust.sv */
// ----------------------------------------------------------------------------
// lgo_adjust
// Per-pixel gain, rounding, signed offset and clamp to 0..255; pass-through
// when the row is not in an adjusted band.
// ----------------------------------------------------------------------------
module lgo_adjust (
	input  logic [lgo_pkg::PixW-1:0] pixel,
	input  logic                     active,
	input  lgo_pkg::adj_cfg_t        cfg,
	output logic [lgo_pkg::PixW-1:0] result
);

	logic [lgo_pkg::ProdW-1:0]   prod;
	logic [lgo_pkg::ProdW-1:0]   rounded;
	logic [lgo_pkg::ScaledW-1:0] scaled;
	logic signed [lgo_pkg::SumW-1:0] sum;
	logic [lgo_pkg::PixW-1:0]    clamped;

	// 8x9 product cannot overflow 17 bits even with the rounding term
	assign prod    = lgo_pkg::ProdW'(pixel) * lgo_pkg::ProdW'(cfg.gain);
	assign rounded = prod + lgo_pkg::Round;
	assign scaled  = rounded[lgo_pkg::ProdW-1:lgo_pkg::Shift];
	assign sum     = $signed({2'b00, scaled})
		+ $signed({{(lgo_pkg::SumW-lgo_pkg::OffsetW){cfg.offset[lgo_pkg::OffsetW-1]}},
			cfg.offset});

	always_comb begin
		if (sum[lgo_pkg::SumW-1]) begin
			clamped = '0;
		end else if (sum[lgo_pkg::SumW-2:lgo_pkg::PixW] != '0) begin
			clamped = lgo_pkg::PixMax;
		end else begin
			clamped = sum[lgo_pkg::PixW-1:0];
		end
	end

	assign result = active ? clamped : pixel;

endmodule

/* sv/luma_gain_offset_scanline_top.sv */
// ----------------------------------------------------------------------------
// luma_gain_offset_scanline_top
// Luma gain/offset with banded-row scanline effect on a raster pixel stream.
// ----------------------------------------------------------------------------
// Usage:
//   pix_in  : one luma sample per request, with line_end / frame_end markers.
//   pix_out : the adjusted or passed-through sample with the markers copied.
//   cfg     : register writes (0 gain, 1 offset, 2 scanline_step); always
//             ready, write only while no request is in flight.
// Each request takes one result, through the input register and then the
// result register, with the single multiply between the two. Throughput is
// one request per clock while pix_out.ready stays high.
// The row band is decided at input acceptance from the current row phase;
// the phase steps on line_end and clears on frame_end.
// A stalled receiver holds the result register; the input register still
// takes one more request, after which pix_in.ready drops.
// Reset clears both stages and the row phase and loads gain 128 (unity),
// offset 0 and scanline_step 0 (all rows adjusted).
// ----------------------------------------------------------------------------
module luma_gain_offset_scanline_top (
	input logic            clk,
	input logic            arst_n,
	lgo_pix_in_if.sink     pix_in,
	lgo_pix_out_if.source  pix_out,
	lgo_cfg_if.sink        cfg
);

	logic [lgo_pkg::GainW-1:0]   gain_q;
	logic [lgo_pkg::OffsetW-1:0] offset_q;
	logic [lgo_pkg::StepW-1:0]   step_q;
	logic [lgo_pkg::PhaseW-1:0]  row_phase_q;
	logic [lgo_pkg::PhaseW-1:0]  phase_inc;
	logic [lgo_pkg::PhaseW-1:0]  band_pair;

	logic                       valid_s1;
	logic [lgo_pkg::PixW-1:0]   pixel_s1;
	logic                       active_s1;
	logic                       line_end_s1;
	logic                       frame_end_s1;

	logic                       valid_s2;
	logic [lgo_pkg::PixW-1:0]   pixel_s2;
	logic                       line_end_s2;
	logic                       frame_end_s2;

	logic                       in_fire;
	logic                       s1_fire;
	logic                       active;
	lgo_pkg::adj_cfg_t          adj_cfg;
	logic [lgo_pkg::PixW-1:0]   adj_result;

	// configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q   <= lgo_pkg::GainReset;
			offset_q <= lgo_pkg::OffsetReset;
			step_q   <= lgo_pkg::StepReset;
		end else if (cfg.valid) begin
			case (cfg.index)
				lgo_pkg::REG_GAIN:   gain_q   <= cfg.data[lgo_pkg::GainW-1:0];
				lgo_pkg::REG_OFFSET: offset_q <= cfg.data[lgo_pkg::OffsetW-1:0];
				lgo_pkg::REG_STEP:   step_q   <= cfg.data[lgo_pkg::StepW-1:0];
				default: ;
			endcase
		end
	end

	// handshakes
	assign s1_fire      = valid_s1 && (!valid_s2 || pix_out.ready);
	assign pix_in.ready = !valid_s1 || s1_fire;
	assign in_fire      = pix_in.valid && pix_in.ready;

	// row band and phase
	assign band_pair = {step_q, 1'b0};
	assign phase_inc = row_phase_q + lgo_pkg::PhaseW'(1);
	assign active    = (step_q == '0) || (row_phase_q < lgo_pkg::PhaseW'(step_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_phase_q <= '0;
		end else if (in_fire) begin
			if (pix_in.frame_end) begin
				row_phase_q <= '0;
			end else if (pix_in.line_end) begin
				// a phase left from a larger step wraps at the next row end
				if (step_q == '0 || phase_inc >= band_pair) begin
					row_phase_q <= '0;
				end else begin
					row_phase_q <= phase_inc;
				end
			end
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pix_in.ready) begin
			valid_s1 <= pix_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			pixel_s1     <= pix_in.pixel;
			active_s1    <= active;
			line_end_s1  <= pix_in.line_end;
			frame_end_s1 <= pix_in.frame_end;
		end
	end

	assign adj_cfg.gain   = gain_q;
	assign adj_cfg.offset = offset_q;

	lgo_adjust u_adjust (
		.pixel  (pixel_s1),
		.active (active_s1),
		.cfg    (adj_cfg),
		.result (adj_result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || pix_out.ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			pixel_s2     <= adj_result;
			line_end_s2  <= line_end_s1;
			frame_end_s2 <= frame_end_s1;
		end
	end

	assign pix_out.valid            = valid_s2;
	assign pix_out.result_pixel     = pixel_s2;
	assign pix_out.result_line_end  = line_end_s2;
	assign pix_out.result_frame_end = frame_end_s2;

`ifndef ASSERT_OFF
	a_frame_end_clears_phase: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && pix_in.frame_end |=> row_phase_q == '0)
		else $error("row phase not cleared after frame end");

	a_skip_row_passes: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && !active_s1 |=> pix_out.result_pixel == $past(pixel_s1))
		else $error("skipped row pixel altered");

	a_unity_is_identity: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && active_s1 && gain_q == lgo_pkg::GainReset && offset_q == '0
		|=> pix_out.result_pixel == $past(pixel_s1))
		else $error("unity gain with zero offset changed the pixel");

	a_markers_follow: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire |=> pix_out.result_line_end == $past(line_end_s1)
			&& pix_out.result_frame_end == $past(frame_end_s1))
		else $error("markers lost between stages");
`endif

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the luma gain/offset scanline block: directed
// corner pixels and register extremes, then random raster frames under
// several register settings, with random idle cycles on both channels.
// ----------------------------------------------------------------------------
module tb;

	localparam int ROUND_TERM    = 64;
	localparam int SCALE_SHIFT   = 7;
	localparam int WATCHDOG_MAX  = 2000;
	localparam int PHASE_ITEMS   = 100;
	localparam int RAND_PHASES   = 8;
	localparam int MAX_REPORTS   = 40;

	typedef struct {
		logic [lgo_pkg::PixW-1:0] pixel;
		logic                     line_end;
		logic                     frame_end;
	} luma_out_t;

	// Tracks register state and row band, holds the outputs still owed.
	class luma_scoreboard;
		logic [lgo_pkg::GainW-1:0]          gain      = lgo_pkg::GainReset;
		logic signed [lgo_pkg::OffsetW-1:0] offset    = '0;
		logic [lgo_pkg::StepW-1:0]          step      = '0;
		logic [lgo_pkg::PhaseW-1:0]         row_phase = '0;
		luma_out_t                          owed_q[$];
		int                                 errors    = 0;

		task report(string msg);
			if (errors < MAX_REPORTS)
				$display("tb: mismatch at %0t: %s", $time, msg);
			errors++;
		endtask

		function void set_reg(lgo_pkg::reg_idx_t idx, logic [lgo_pkg::CfgDataW-1:0] data);
			case (idx)
				lgo_pkg::REG_GAIN: begin
					gain = data[lgo_pkg::GainW-1:0];
				end
				lgo_pkg::REG_OFFSET: begin
					offset = data[lgo_pkg::OffsetW-1:0];
				end
				lgo_pkg::REG_STEP: begin
					step = data[lgo_pkg::StepW-1:0];
				end
				default: begin
				end
			endcase
		endfunction

		function logic [lgo_pkg::PixW-1:0] adjusted(logic [lgo_pkg::PixW-1:0] p);
			int scaled;
			int total;
			scaled = (int'(p) * int'(gain) + ROUND_TERM) >>> SCALE_SHIFT;
			total  = scaled + int'(offset);
			if (total < 0)
				total = 0;
			if (total > 255)
				total = 255;
			return lgo_pkg::PixW'(total);
		endfunction

		function void note_request(logic [lgo_pkg::PixW-1:0] p, logic le, logic fe);
			luma_out_t r;
			int        nxt;
			bit        in_band;
			in_band     = (step == 0) || (row_phase < lgo_pkg::PhaseW'(step));
			r.pixel     = in_band ? adjusted(p) : p;
			r.line_end  = le;
			r.frame_end = fe;
			owed_q.push_back(r);
			if (fe) begin
				row_phase = '0;
			end else if (le) begin
				nxt = int'(row_phase) + 1;
				if (step == 0 || nxt >= 2 * int'(step))
					nxt = 0;
				row_phase = lgo_pkg::PhaseW'(nxt);
			end
		endfunction

		task check_result(logic [lgo_pkg::PixW-1:0] p, logic le, logic fe);
			luma_out_t e;
			if (owed_q.size() == 0) begin
				report($sformatf("unexpected output pixel=%0d le=%0b fe=%0b", p, le, fe));
			end else begin
				e = owed_q.pop_front();
				if (p !== e.pixel || le !== e.line_end || fe !== e.frame_end)
					report($sformatf(
						"got pixel=%0d le=%0b fe=%0b, want pixel=%0d le=%0b fe=%0b",
						p, le, fe, e.pixel, e.line_end, e.frame_end));
			end
		endtask

		function int pending();
			return owed_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   steady;
	int   idle_cycles;

	lgo_pix_in_if  pix_in();
	lgo_pix_out_if pix_out();
	lgo_cfg_if     cfg();

	luma_scoreboard sb;

	luma_gain_offset_scanline_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix_in  (pix_in),
		.pix_out (pix_out),
		.cfg     (cfg)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Output back-pressure: ~18% stall cycles, none while steady.
	initial begin
		pix_out.ready <= 1'b0;
		forever begin
			@(posedge clk);
			pix_out.ready <= steady || ($urandom_range(99) >= 18);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (pix_in.valid && pix_in.ready)
				sb.note_request(pix_in.pixel, pix_in.line_end, pix_in.frame_end);
			if (pix_out.valid && pix_out.ready)
				sb.check_result(pix_out.result_pixel, pix_out.result_line_end,
					pix_out.result_frame_end);
			if (cfg.valid && cfg.ready)
				sb.set_reg(lgo_pkg::reg_idx_t'(cfg.index), cfg.data);
			if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready) ||
				(cfg.valid && cfg.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_MAX) begin
				$display("tb: FAIL");
				$finish;
			end
		end
	end

	task automatic send_pixel(logic [lgo_pkg::PixW-1:0] p, logic le, logic fe);
		if (!steady) begin
			while ($urandom_range(99) < 18) begin
				pix_in.valid <= 1'b0;
				@(posedge clk);
			end
		end
		pix_in.valid     <= 1'b1;
		pix_in.pixel     <= p;
		pix_in.line_end  <= le;
		pix_in.frame_end <= fe;
		do @(posedge clk); while (!pix_in.ready);
	endtask

	// Stop requests and wait until every owed output has come back.
	task automatic drain();
		pix_in.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic load_regs(logic [lgo_pkg::GainW-1:0] g,
		logic signed [lgo_pkg::OffsetW-1:0] o, logic [lgo_pkg::StepW-1:0] s);
		lgo_pkg::reg_idx_t            idx [3];
		logic [lgo_pkg::CfgDataW-1:0] val [3];
		idx = '{lgo_pkg::REG_GAIN, lgo_pkg::REG_OFFSET, lgo_pkg::REG_STEP};
		val = '{lgo_pkg::CfgDataW'(g), lgo_pkg::CfgDataW'(o), lgo_pkg::CfgDataW'(s)};
		drain();
		for (int i = 0; i < 3; i++) begin
			cfg.valid <= 1'b1;
			cfg.index <= idx[i];
			cfg.data  <= val[i];
			do @(posedge clk); while (!cfg.ready);
		end
		cfg.valid <= 1'b0;
	endtask

	function automatic logic [lgo_pkg::PixW-1:0] rand_pixel();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return lgo_pkg::PixW'($urandom);
		endcase
	endfunction

	// Raster frames with random row lengths; a few markers are scrambled.
	task automatic send_frames(int target);
		int  sent;
		int  rows;
		int  len;
		bit  le;
		bit  fe;
		sent = 0;
		while (sent < target) begin
			rows = $urandom_range(1, 10);
			for (int r = 0; r < rows && sent < target; r++) begin
				len = $urandom_range(1, 12);
				for (int c = 0; c < len && sent < target; c++) begin
					le = (c == len - 1);
					fe = le && (r == rows - 1);
					if ($urandom_range(99) < 8) begin
						le = 1'($urandom_range(1));
						fe = 1'($urandom_range(1));
					end
					send_pixel(rand_pixel(), le, fe);
					sent++;
				end
			end
		end
	endtask

	initial begin
		logic [lgo_pkg::GainW-1:0]          g;
		logic signed [lgo_pkg::OffsetW-1:0] o;
		logic [lgo_pkg::StepW-1:0]          s;
		sb               = new();
		steady           = 1'b0;
		idle_cycles      = 0;
		arst_n           = 1'b0;
		pix_in.valid     <= 1'b0;
		pix_in.pixel     <= '0;
		pix_in.line_end  <= 1'b0;
		pix_in.frame_end <= 1'b0;
		cfg.valid        <= 1'b0;
		cfg.index        <= lgo_pkg::REG_GAIN;
		cfg.data         <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: unity gain, all rows adjusted, marker combinations
		send_pixel(8'd0,   1'b0, 1'b0);
		send_pixel(8'd255, 1'b0, 1'b0);
		send_pixel(8'd1,   1'b1, 1'b0);
		send_pixel(8'd128, 1'b0, 1'b1);
		send_pixel(8'd200, 1'b1, 1'b1);

		// gain past 256 at full width, offset at its most negative
		load_regs(9'd511, -10'sd512, 8'd0);
		send_pixel(8'd255, 1'b0, 1'b0);
		send_pixel(8'd0,   1'b1, 1'b0);

		// zero gain with top offset saturates high
		load_regs(9'd0, 10'sd511, 8'd0);
		send_pixel(8'd170, 1'b0, 1'b0);

		load_regs(9'd256, -10'sd256, 8'd0);
		send_pixel(8'd255, 1'b0, 1'b0);
		send_pixel(8'd0,   1'b1, 1'b1);

		// three-row bands, one pixel per row: rows 3 and 4 pass through
		load_regs(9'd300, 10'sd17, 8'd3);
		for (int i = 0; i < 5; i++)
			send_pixel(8'(37 * i + 60), 1'b1, 1'b0);

		// step shrinks mid-frame: leftover phase is a skipped row, then wraps
		load_regs(9'd300, 10'sd17, 8'd1);
		send_pixel(8'd90,  1'b1, 1'b0);
		send_pixel(8'd91,  1'b1, 1'b0);
		send_pixel(8'd92,  1'b1, 1'b0);
		// frame end alone clears the phase
		send_pixel(8'd93,  1'b0, 1'b1);
		send_pixel(8'd94,  1'b1, 1'b0);
		send_pixel(8'd95,  1'b0, 1'b0);

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			case (ph)
				0: begin
					g = 9'd128; o = '0; s = 8'd0;
				end
				1: begin
					g = 9'd256; o = 10'sd256; s = 8'd255;
				end
				2: begin
					g = 9'd0; o = -10'sd256; s = 8'd1;
				end
				3: begin
					g = 9'd511; o = -10'sd512; s = 8'd2;
				end
				default: begin
					g = ($urandom_range(3) == 0) ? lgo_pkg::GainW'($urandom)
						: lgo_pkg::GainW'($urandom_range(256));
					o = lgo_pkg::OffsetW'($urandom_range(512)) - 10'sd256;
					s = lgo_pkg::StepW'($urandom_range(5));
				end
			endcase
			load_regs(g, o, s);
			steady = (ph == 2);
			send_frames(PHASE_ITEMS / 2);
			// hold requests until the pipeline is empty, then resume
			drain();
			send_frames(PHASE_ITEMS / 2);
			steady = 1'b0;
		end

		drain();
		repeat (10) @(posedge clk);
		if (sb.errors == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule
